FILE: hdl/kic_pkg.sv
// Shared types and constants for the key and IV pair cache.
package kic_pkg;

	// Fixed field widths.
	localparam int KEY_WORD_W = 64;
	localparam int STAMP_W    = 32;
	localparam int SLOT_W     = 10;
	localparam int CFG_W      = 11;
	localparam int KV_W       = 6 * KEY_WORD_W;

	// Reset value of the active slot count.
	localparam logic [CFG_W-1:0] CFG_ACTIVE_RESET = 11'd1024;

	// Operation codes.
	localparam logic OP_FILL   = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	// One request as it arrives on the command port.
	typedef struct packed {
		logic                  op;
		logic [KEY_WORD_W-1:0] key_word0;
		logic [KEY_WORD_W-1:0] key_word1;
		logic [KEY_WORD_W-1:0] key_word2;
		logic [KEY_WORD_W-1:0] key_word3;
		logic [KEY_WORD_W-1:0] iv_word0;
		logic [KEY_WORD_W-1:0] iv_word1;
		logic [STAMP_W-1:0]    now_seconds;
	} req_t;

	// One result.
	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] slot_index;
		logic              filled;
	} rsp_t;

	// Control from the sequencer to the scan unit.
	typedef struct packed {
		logic clear;
		logic eval;
	} scan_ctl_t;

	// Packs key and IV into one memory word.
	function automatic logic [KV_W-1:0] kv_pack(req_t r);
		return {r.key_word3, r.key_word2, r.key_word1, r.key_word0, r.iv_word1, r.iv_word0};
	endfunction

endpackage

FILE: hdl/key_iv_cache_lru_replace_core.sv
// Flow: an accepted start scans m slots, where m = min(active_entries, ENTRIES, number of
// valid slots), stopping early on a hit; the write-back state follows (at once when m is
// zero), and the done strobe is registered from it. A new request is taken only in idle.
// The scan reads one slot per cycle from the key/IV memory and the stamp memory.
// Reset: valid slots are tracked by a fill count, so the cache is empty and ready right
// after reset with no clearing pass; the result port has no back-pressure.
module key_iv_cache_lru_replace_core #(
	parameter int ENTRIES = 1024
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  kic_pkg::req_t            request,
	output logic                     done,
	output kic_pkg::rsp_t            result,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [kic_pkg::CFG_W-1:0] cfg_data
);
	import kic_pkg::*;

	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SCAN  = 3'b010,
		ST_WRITE = 3'b100
	} state_t;

	state_t         state_q;
	logic [CFG_W-1:0] cfg_active_q;
	logic [CW-1:0]  fill_q;
	logic [CW-1:0]  lim_q;
	logic [CW-1:0]  len_q;
	logic [CW-1:0]  cnt_q;
	req_t           req_q;
	logic           hit_q;
	logic [AW-1:0]  hit_idx_q;
	logic           rd_v_s1;
	logic           last_s1;
	logic [AW-1:0]  idx_s1;
	logic           done_q;
	rsp_t           result_q;

	logic           accept;
	logic [CW-1:0]  lim;
	logic [CW-1:0]  len;
	logic           rd_en;
	logic           scan_end;
	scan_ctl_t      scan_ctl;
	logic           match;
	logic [AW-1:0]  best_idx;
	logic [AW-1:0]  victim;
	logic [AW-1:0]  slot;
	logic           kv_we;
	logic           st_we;
	logic [KV_W-1:0]    rd_kv;
	logic [STAMP_W-1:0] rd_stamp;

	// Command and configuration handshakes.
	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	// Scan length: the active count capped at the depth, then at the valid prefix.
	always_comb begin
		if (int'(cfg_active_q) < ENTRIES) begin
			lim = CW'(cfg_active_q);
		end else begin
			lim = CW'(ENTRIES);
		end
		len = (lim < fill_q) ? lim : fill_q;
	end

	// Read issue and end-of-scan detection.
	assign rd_en    = (state_q == ST_SCAN) && (cnt_q < len_q);
	assign scan_end = (state_q == ST_SCAN) && rd_v_s1 && (match || last_s1);

	assign scan_ctl.clear = accept;
	assign scan_ctl.eval  = (state_q == ST_SCAN) && rd_v_s1;

	// Victim: the first invalid slot if one is active, else the oldest stamp strictly below the request time, else slot 0.
	assign victim = (fill_q < lim_q) ? fill_q[AW-1:0] : best_idx;

	always_comb begin
		if (hit_q) begin
			slot = hit_idx_q;
		end else if (req_q.op == OP_FILL) begin
			slot = victim;
		end else begin
			slot = '0;
		end
	end

	assign kv_we = (state_q == ST_WRITE) && !hit_q && (req_q.op == OP_FILL);
	assign st_we = (state_q == ST_WRITE) && (hit_q || (req_q.op == OP_FILL));

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cfg_active_q <= CFG_ACTIVE_RESET;
			fill_q       <= '0;
			lim_q        <= '0;
			len_q        <= '0;
			cnt_q        <= '0;
			hit_q        <= 1'b0;
			rd_v_s1      <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cfg_active_q <= cfg_data;
			end
			rd_v_s1 <= rd_en;
			done_q  <= (state_q == ST_WRITE);
			if (rd_en) begin
				cnt_q <= CW'(cnt_q + 1'b1);
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						lim_q <= lim;
						len_q <= len;
						cnt_q <= '0;
						hit_q <= 1'b0;
						state_q <= (len == '0) ? ST_WRITE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_end) begin
						hit_q   <= match;
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					if (kv_we && (CW'(victim) == fill_q)) begin
						fill_q <= CW'(fill_q + 1'b1);
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request, read pipeline and result payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= request;
		end
		if (rd_en) begin
			idx_s1  <= cnt_q[AW-1:0];
			last_s1 <= (CW'(cnt_q + 1'b1) == len_q);
		end
		if (scan_end) begin
			hit_idx_q <= idx_s1;
		end
		if (state_q == ST_WRITE) begin
			result_q.hit        <= hit_q;
			result_q.slot_index <= SLOT_W'(slot);
			result_q.filled     <= kv_we;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// Key and IV store.
	kic_ram #(
		.WIDTH(KV_W),
		.DEPTH(ENTRIES)
	) u_kv_ram (
		.clk    (clk),
		.wr_en  (kv_we),
		.wr_addr(slot),
		.wr_data(kv_pack(req_q)),
		.rd_en  (rd_en),
		.rd_addr(cnt_q[AW-1:0]),
		.rd_data(rd_kv)
	);

	// Last-used stamp store.
	kic_ram #(
		.WIDTH(STAMP_W),
		.DEPTH(ENTRIES)
	) u_stamp_ram (
		.clk    (clk),
		.wr_en  (st_we),
		.wr_addr(slot),
		.wr_data(req_q.now_seconds),
		.rd_en  (rd_en),
		.rd_addr(cnt_q[AW-1:0]),
		.rd_data(rd_stamp)
	);

	// Match and victim tracking over the scanned slots.
	kic_scan #(
		.AW(AW)
	) u_scan (
		.clk        (clk),
		.ctl        (scan_ctl),
		.idx        (idx_s1),
		.key_iv     (kv_pack(req_q)),
		.start_stamp(request.now_seconds),
		.rd_kv      (rd_kv),
		.rd_stamp   (rd_stamp),
		.match      (match),
		.best_idx   (best_idx)
	);

	// The fill count never runs past the depth.
	assert property (@(posedge clk) disable iff (!arst_n) fill_q <= CW'(ENTRIES))
		else $error("fill count beyond depth");

	// The memories are never read and written in the same cycle.
	assert property (@(posedge clk) disable iff (!arst_n) !(rd_en && (kv_we || st_we)))
		else $error("read and write overlap");

	// A write-back state is followed by a done strobe with the core back in idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE) |=> (done && (state_q == ST_IDLE)))
		else $error("write-back did not produce a result");

	// A hit never also fills.
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !(result.hit && result.filled))
		else $error("hit and fill together");

	// The scan never reads past the valid slots.
	assert property (@(posedge clk) disable iff (!arst_n) rd_en |-> (cnt_q < fill_q))
		else $error("read beyond valid slots");

endmodule

FILE: hdl/kic_ram.sv
// Generic single write port, single read port RAM with registered read data.
module kic_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic                                   rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: hdl/kic_scan.sv
// Per-entry match and least recently used tracking, one entry per cycle.
module kic_scan #(
	parameter int AW = 10
) (
	input  logic                     clk,
	input  kic_pkg::scan_ctl_t       ctl,
	input  logic [AW-1:0]            idx,
	input  logic [kic_pkg::KV_W-1:0] key_iv,
	input  logic [kic_pkg::STAMP_W-1:0] start_stamp,
	input  logic [kic_pkg::KV_W-1:0] rd_kv,
	input  logic [kic_pkg::STAMP_W-1:0] rd_stamp,
	output logic                     match,
	output logic [AW-1:0]            best_idx
);
	import kic_pkg::*;

	logic [STAMP_W-1:0] best_stamp_q;
	logic [AW-1:0]      best_idx_q;

	// Compare the entry read this cycle against the request.
	assign match = ctl.eval && (rd_kv == key_iv);

	// Keep the oldest stamp strictly below the request time; lower index wins ties.
	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			best_stamp_q <= start_stamp;
			best_idx_q   <= '0;
		end else if (ctl.eval && (rd_stamp < best_stamp_q)) begin
			best_stamp_q <= rd_stamp;
			best_idx_q   <= idx;
		end
	end

	assign best_idx = best_idx_q;

endmodule

FILE: test/key_iv_cache_lru_replace_core_tb.sv
// Self-checking testbench for the key and IV pair cache with time stamp LRU replacement.
`timescale 1ns / 1ps

module key_iv_cache_lru_replace_core_tb;
	import kic_pkg::*;

	localparam int ENTRIES     = 1024;
	localparam int STALL_LIMIT = 4000;

	// One key and IV pair as the stimulus side handles it.
	typedef struct packed {
		logic [4*KEY_WORD_W-1:0] key;
		logic [2*KEY_WORD_W-1:0] iv;
	} kv_pair_t;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             start     = 1'b0;
	logic             busy;
	req_t             request   = '0;
	logic             done;
	rsp_t             result;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CFG_W-1:0] cfg_data  = '0;

	// Shadow copy of the cache contents and the active slot count.
	logic [CFG_W-1:0]        active_cnt = CFG_ACTIVE_RESET;
	bit                      line_live  [ENTRIES];
	logic [4*KEY_WORD_W-1:0] line_key   [ENTRIES];
	logic [2*KEY_WORD_W-1:0] line_iv    [ENTRIES];
	logic [STAMP_W-1:0]      line_stamp [ENTRIES];

	rsp_t               pending_rsp [$];
	kv_pair_t           recent_pairs [$];
	kv_pair_t           probe [6];
	int                 mismatch_count = 0;
	int                 stall_cycles   = 0;
	int                 gap_max        = 9;
	logic [STAMP_W-1:0] wall_time      = '0;

	key_iv_cache_lru_replace_core #(
		.ENTRIES(ENTRIES)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.request  (request),
		.done     (done),
		.result   (result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	// 50 MHz clock.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Look up one request in the shadow cache, update it, and return the expected result.
	function automatic rsp_t predict_access(req_t r);
		logic [4*KEY_WORD_W-1:0] k;
		logic [2*KEY_WORD_W-1:0] v;
		logic [STAMP_W-1:0]      oldest;
		int                      n;
		int                      i;
		int                      match;
		int                      victim;
		bit                      free_found;
		rsp_t                    o;
		k = {r.key_word3, r.key_word2, r.key_word1, r.key_word0};
		v = {r.iv_word1, r.iv_word0};
		n = (active_cnt < ENTRIES) ? int'(active_cnt) : ENTRIES;
		o = '0;
		match = -1;
		for (i = 0; i < n && match < 0; i++)
			if (line_live[i] && line_key[i] == k && line_iv[i] == v)
				match = i;
		if (match >= 0) begin
			// A hit refreshes the stamp, whatever the operation.
			line_stamp[match] = r.now_seconds;
			o.hit = 1'b1;
			o.slot_index = match[SLOT_W-1:0];
		end else if (r.op == OP_FILL) begin
			// The first free slot wins; else the oldest stamp strictly below now, else slot 0.
			victim = 0;
			oldest = r.now_seconds;
			free_found = 1'b0;
			for (i = 0; i < n && !free_found; i++) begin
				if (!line_live[i]) begin
					victim = i;
					free_found = 1'b1;
				end else if (line_stamp[i] < oldest) begin
					oldest = line_stamp[i];
					victim = i;
				end
			end
			line_live[victim]  = 1'b1;
			line_key[victim]   = k;
			line_iv[victim]    = v;
			line_stamp[victim] = r.now_seconds;
			o.slot_index = victim[SLOT_W-1:0];
			o.filled = 1'b1;
		end
		return o;
	endfunction

	function automatic kv_pair_t rand_pair();
		kv_pair_t p;
		p.key = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		p.iv  = {$urandom, $urandom, $urandom, $urandom};
		return p;
	endfunction

	// Present one request, wait for its transfer, record the expected result, then idle for a random gap, if any.
	task automatic send_request(input logic op_code, input kv_pair_t p,
			input logic [STAMP_W-1:0] t);
		req_t r;
		int   gap;
		r.op          = op_code;
		r.key_word0   = p.key[63:0];
		r.key_word1   = p.key[127:64];
		r.key_word2   = p.key[191:128];
		r.key_word3   = p.key[255:192];
		r.iv_word0    = p.iv[63:0];
		r.iv_word1    = p.iv[127:64];
		r.now_seconds = t;
		start <= 1'b1;
		request <= r;
		do
			@(posedge clk);
		while (busy);
		pending_rsp.push_back(predict_access(r));
		gap = $urandom_range(0, gap_max);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Wait until every outstanding result has come back.
	task automatic drain();
		start <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
	endtask

	// Change the active slot count while the cache is idle.
	task automatic set_active(input logic [CFG_W-1:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		active_cnt = value;
	endtask

	// Empty cache, all-zero and all-one fields, hits with both operations.
	task automatic test_empty_and_extremes();
		kv_pair_t zeros;
		kv_pair_t ones;
		zeros = '0;
		ones = '1;
		send_request(OP_LOOKUP, zeros, 32'd5);
		send_request(OP_FILL, zeros, 32'd0);
		send_request(OP_FILL, ones, 32'hFFFF_FFFF);
		send_request(OP_LOOKUP, zeros, 32'd7);
		send_request(OP_FILL, ones, 32'd100);
		send_request(OP_LOOKUP, rand_pair(), 32'd8);
	endtask

	// Victim choice: free slot first, oldest stamp, ties, and no stamp below now.
	task automatic test_victim_choice();
		for (int i = 0; i < 6; i++)
			probe[i] = rand_pair();
		set_active(11'd4);
		send_request(OP_FILL, probe[0], 32'd50);
		send_request(OP_FILL, probe[1], 32'd60);
		send_request(OP_FILL, probe[2], 32'd55);
		send_request(OP_FILL, probe[3], 32'd10);
		send_request(OP_LOOKUP, probe[0], 32'd20);
		send_request(OP_LOOKUP, probe[1], 32'd20);
		send_request(OP_LOOKUP, probe[3], 32'd20);
		send_request(OP_FILL, probe[4], 32'd30);
		send_request(OP_FILL, probe[5], 32'd20);
	endtask

	// With no active slots every request misses and a fill lands in slot 0.
	task automatic test_zero_active();
		set_active(11'd0);
		send_request(OP_LOOKUP, probe[0], 32'd150);
		send_request(OP_FILL, probe[1], 32'd200);
	endtask

	// Slots past the active count are neither searched nor replaced, and keep their contents.
	task automatic test_hidden_slots();
		set_active(11'd2);
		send_request(OP_LOOKUP, probe[0], 32'd210);
		send_request(OP_FILL, probe[0], 32'd220);
		set_active(11'd4);
		send_request(OP_LOOKUP, probe[0], 32'd230);
		send_request(OP_LOOKUP, probe[1], 32'd240);
	endtask

	// An active count above the slot count uses all slots.
	task automatic test_oversized_count();
		kv_pair_t ones;
		ones = '1;
		set_active(11'd2047);
		send_request(OP_FILL, rand_pair(), 32'd300);
		send_request(OP_LOOKUP, probe[0], 32'd310);
		send_request(OP_FILL, ones, 32'hFFFF_FFFF);
	endtask

	// Random traffic at one active count: reused pairs, near misses and fresh pairs.
	task automatic random_phase(input int items, input logic [CFG_W-1:0] act, input int gmax);
		kv_pair_t                p;
		logic [6*KEY_WORD_W-1:0] flat;
		logic                    op_code;
		int                      pool_cap;
		int                      pick;
		set_active(act);
		gap_max = gmax;
		pool_cap = (act < 12) ? int'(act) + 3 : 24;
		recent_pairs.delete();
		for (int n = 0; n < items; n++) begin
			pick = $urandom_range(0, 99);
			if (recent_pairs.size() != 0 && pick < 50) begin
				p = recent_pairs[$urandom_range(0, recent_pairs.size() - 1)];
			end else if (recent_pairs.size() != 0 && pick < 60) begin
				flat = recent_pairs[$urandom_range(0, recent_pairs.size() - 1)];
				pick = $urandom_range(0, 6 * KEY_WORD_W - 1);
				flat[pick] = ~flat[pick];
				p = flat;
			end else begin
				p = rand_pair();
				recent_pairs.push_back(p);
				if (recent_pairs.size() > pool_cap)
					void'(recent_pairs.pop_front());
			end
			// Time mostly creeps forward so that stamps tie, with jumps and steps back.
			case ($urandom_range(0, 19))
				0:       wall_time = $urandom;
				1:       wall_time = '1;
				2:       wall_time = '0;
				3:       wall_time = wall_time - $urandom_range(0, 20);
				default: wall_time = wall_time + $urandom_range(0, 3);
			endcase
			op_code = ($urandom_range(0, 3) == 0) ? OP_LOOKUP : OP_FILL;
			send_request(op_code, p, wall_time);
		end
	endtask

	task automatic test_random_traffic();
		random_phase(120, 11'd8, 9);
		random_phase(100, 11'd3, 0);
		random_phase(80, 11'd1, 9);
		random_phase(40, 11'd0, 5);
		random_phase(120, 11'd16, 9);
		random_phase(60, 11'd1024, 3);
		random_phase(40, 11'd2047, 9);
	endtask

	// Compare each result with the oldest expectation.
	always @(posedge clk) begin : check_results
		rsp_t want;
		if (arst_n && done) begin
			if (pending_rsp.size() == 0) begin
				$error("result with no request outstanding");
				mismatch_count++;
			end else begin
				want = pending_rsp.pop_front();
				if (result.hit !== want.hit) begin
					$error("hit: expected %0d, got %0d", want.hit, result.hit);
					mismatch_count++;
				end
				if (result.slot_index !== want.slot_index) begin
					$error("slot_index: expected %0d, got %0d", want.slot_index,
						result.slot_index);
					mismatch_count++;
				end
				if (result.filled !== want.filled) begin
					$error("filled: expected %0d, got %0d", want.filled, result.filled);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Test sequence.
	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_and_extremes();
		test_victim_choice();
		test_zero_active();
		test_hidden_slots();
		test_oversized_count();
		test_random_traffic();
		drain();
		repeat (40) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
